/* hw/rtl/packed_symbol_tape_assert.svh */
// assertion macros for the packed symbol tape
`ifndef PACKED_SYMBOL_TAPE_ASSERT_SVH
`define PACKED_SYMBOL_TAPE_ASSERT_SVH

// same-cycle implication
`define PST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("packed_symbol_tape: same-cycle check failed");

// next-cycle implication
`define PST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("packed_symbol_tape: next-cycle check failed");

`endif

/* hw/rtl/pst_pkg.sv */
// types and constants of the packed symbol tape
`timescale 1ns / 1ps

package pst_pkg;

  localparam int unsigned TAPE_WORDS = 1024;
  localparam int unsigned TAPE_AW    = $clog2(TAPE_WORDS);

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned SYM_W      = 63;
  localparam int unsigned WIDTH_W    = 6;
  localparam int unsigned LEN_W      = 17;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned BIT_W      = POS_W + WIDTH_W;
  localparam int unsigned LO_W       = $clog2(WORD_W);
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = LEN_W;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(65536);

  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPE_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION = 2'd2;

  typedef enum logic [1:0] {
    OP_READ       = 2'd0,
    OP_WRITE      = 2'd1,
    OP_MOVE_LEFT  = 2'd2,
    OP_MOVE_RIGHT = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_WR1
  } state_t;

endpackage

/* hw/rtl/packed_symbol_tape.sv */
// packed symbol tape: head control, tape memory and result registers
`timescale 1ns / 1ps

// A move's result strobes on out_valid in the cycle after start, and a new item may start in
// that same cycle. A read or a write passes through the states RD0, RD1 and RD2 before its
// result, and a write whose symbol straddles two words also passes through WR1, because the
// single-port tape memory first reads the first and second word and then writes them back
// one at a time. busy is low exactly when an item may start. After reset the block runs a
// clearing pass over the tape memory, one word a cycle, and stays busy until every word is
// cleared; configuration writes are taken throughout. Each result is valid for exactly one
// cycle and cannot be held off by the receiver.
module packed_symbol_tape (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_op,
  input  logic [pst_pkg::SYM_W-1:0]         in_write_symbol,
  output logic                              out_valid,
  output logic [pst_pkg::SYM_W-1:0]         out_read_symbol,
  output logic [pst_pkg::POS_W-1:0]         out_head_position,
  output logic                              out_out_of_range,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pst_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned WORD_W  = pst_pkg::WORD_W;
  localparam int unsigned TAPE_AW = pst_pkg::TAPE_AW;
  localparam int unsigned BIT_W   = pst_pkg::BIT_W;
  localparam int unsigned LO_W    = pst_pkg::LO_W;
  localparam int unsigned POS_W   = pst_pkg::POS_W;
  localparam int unsigned LEN_W   = pst_pkg::LEN_W;
  localparam int unsigned WIDTH_W = pst_pkg::WIDTH_W;
  localparam int unsigned SYM_W   = pst_pkg::SYM_W;
  localparam logic [TAPE_AW-1:0] LAST_WORD = TAPE_AW'(pst_pkg::TAPE_WORDS - 1);

  // tape memory
  logic [WORD_W-1:0]  mem [pst_pkg::TAPE_WORDS];
  logic [WORD_W-1:0]  mem_q_r;
  logic               mem_we;
  logic [TAPE_AW-1:0] mem_addr;
  logic [WORD_W-1:0]  mem_wdata;

  pst_pkg::state_t    state_r, state_nxt;
  logic [TAPE_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [POS_W-1:0]   head_r, head_nxt;
  logic [WIDTH_W-1:0] width_r, width_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               out_valid_r, out_valid_nxt;

  pst_pkg::op_t       op_r, op_nxt;
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic [WORD_W-1:0]  d0_r, d0_nxt;
  logic [WORD_W-1:0]  new1_r, new1_nxt;
  logic [SYM_W-1:0]   out_sym_r, out_sym_nxt;
  logic [POS_W-1:0]   out_head_r, out_head_nxt;
  logic               out_oor_r, out_oor_nxt;

  logic [WIDTH_W-1:0] eff_w;
  logic [LEN_W-1:0]   eff_len;
  logic [BIT_W-1:0]   prod;
  logic [LO_W-1:0]    lo;
  logic [TAPE_AW-1:0] w0, w1;
  logic [LO_W:0]      sh;
  logic               straddle;
  logic [WORD_W-1:0]  mask, sym_ext, rd, new0, new1;
  logic [POS_W-1:0]   head_dec, head_inc;
  logic               left_ok, right_ok;
  logic               move_req;

  // effective configuration and addressing
  always_comb begin
    eff_w    = (width_r == '0) ? WIDTH_W'(1) : width_r;
    if (len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_r > pst_pkg::LEN_MAX) begin
      eff_len = pst_pkg::LEN_MAX;
    end else begin
      eff_len = len_r;
    end
    prod     = BIT_W'(head_r) * BIT_W'(eff_w);
    lo       = bit_r[LO_W-1:0];
    w0       = bit_r[LO_W +: TAPE_AW];
    w1       = (w0 == LAST_WORD) ? '0 : w0 + TAPE_AW'(1);
    straddle = ({1'b0, lo} + (LO_W + 1)'(eff_w)) > (LO_W + 1)'(WORD_W);
    sh       = (LO_W + 1)'(WORD_W) - {1'b0, lo};
    mask     = (WORD_W'(1) << eff_w) - WORD_W'(1);
    sym_ext  = {1'b0, sym_r} & mask;
    rd       = ((d0_r >> lo) & mask) | (straddle ? ((mem_q_r << sh) & mask) : '0);
    new0     = (d0_r & ~(mask << lo)) | (sym_ext << lo);
    new1     = (mem_q_r & ~(mask >> sh)) | (sym_ext >> sh);
    head_dec = head_r - POS_W'(1);
    head_inc = head_r + POS_W'(1);
    left_ok  = (head_r != '0) && ({1'b0, head_dec} < eff_len);
    right_ok = ({1'b0, head_r} + LEN_W'(1)) < eff_len;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    head_nxt      = head_r;
    width_nxt     = width_r;
    len_nxt       = len_r;
    out_valid_nxt = 1'b0;
    op_nxt        = op_r;
    sym_nxt       = sym_r;
    bit_nxt       = bit_r;
    d0_nxt        = d0_r;
    new1_nxt      = new1_r;
    out_sym_nxt   = out_sym_r;
    out_head_nxt  = out_head_r;
    out_oor_nxt   = out_oor_r;
    mem_we        = 1'b0;
    mem_addr      = w0;
    mem_wdata     = new0;

    unique case (state_r)
      pst_pkg::ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_addr    = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + TAPE_AW'(1);
        if (clr_cnt_r == LAST_WORD) begin
          state_nxt = pst_pkg::ST_IDLE;
        end
      end
      pst_pkg::ST_IDLE: begin
        if (start) begin
          op_nxt  = pst_pkg::op_t'(in_op);
          sym_nxt = in_write_symbol;
          bit_nxt = prod;
          unique case (pst_pkg::op_t'(in_op))
            pst_pkg::OP_READ, pst_pkg::OP_WRITE: begin
              state_nxt = pst_pkg::ST_RD0;
            end
            pst_pkg::OP_MOVE_LEFT: begin
              out_valid_nxt = 1'b1;
              out_sym_nxt   = '0;
              out_oor_nxt   = !left_ok;
              out_head_nxt  = left_ok ? head_dec : head_r;
              head_nxt      = left_ok ? head_dec : head_r;
            end
            pst_pkg::OP_MOVE_RIGHT: begin
              out_valid_nxt = 1'b1;
              out_sym_nxt   = '0;
              out_oor_nxt   = !right_ok;
              out_head_nxt  = right_ok ? head_inc : head_r;
              head_nxt      = right_ok ? head_inc : head_r;
            end
          endcase
        end
      end
      pst_pkg::ST_RD0: begin
        mem_addr  = w0;
        state_nxt = pst_pkg::ST_RD1;
      end
      pst_pkg::ST_RD1: begin
        mem_addr  = w1;
        d0_nxt    = mem_q_r;
        state_nxt = pst_pkg::ST_RD2;
      end
      pst_pkg::ST_RD2: begin
        out_head_nxt = head_r;
        out_oor_nxt  = 1'b0;
        if (op_r == pst_pkg::OP_WRITE) begin
          mem_we    = 1'b1;
          mem_addr  = w0;
          mem_wdata = new0;
          new1_nxt  = new1;
          out_sym_nxt = '0;
          if (straddle) begin
            state_nxt = pst_pkg::ST_WR1;
          end else begin
            out_valid_nxt = 1'b1;
            state_nxt     = pst_pkg::ST_IDLE;
          end
        end else begin
          out_sym_nxt   = rd[SYM_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = pst_pkg::ST_IDLE;
        end
      end
      pst_pkg::ST_WR1: begin
        mem_we        = 1'b1;
        mem_addr      = w1;
        mem_wdata     = new1_r;
        out_valid_nxt = 1'b1;
        state_nxt     = pst_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pst_pkg::ST_IDLE;
      end
    endcase

    if (cfg_valid) begin
      unique case (cfg_index)
        pst_pkg::CFG_SYMBOL_WIDTH:   width_nxt = cfg_data[WIDTH_W-1:0];
        pst_pkg::CFG_TAPE_LENGTH:    len_nxt   = cfg_data[LEN_W-1:0];
        pst_pkg::CFG_START_POSITION: head_nxt  = cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_q_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pst_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      head_r      <= '0;
      width_r     <= WIDTH_W'(1);
      len_r       <= pst_pkg::LEN_MAX;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      head_r      <= head_nxt;
      width_r     <= width_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    sym_r      <= sym_nxt;
    bit_r      <= bit_nxt;
    d0_r       <= d0_nxt;
    new1_r     <= new1_nxt;
    out_sym_r  <= out_sym_nxt;
    out_head_r <= out_head_nxt;
    out_oor_r  <= out_oor_nxt;
  end

  assign busy              = (state_r != pst_pkg::ST_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_read_symbol   = out_sym_r;
  assign out_head_position = out_head_r;
  assign out_out_of_range  = out_oor_r;
  assign move_req          = (in_op == pst_pkg::OP_MOVE_LEFT) ||
                             (in_op == pst_pkg::OP_MOVE_RIGHT);

`include "packed_symbol_tape_assert.svh"

  `PST_ASSERT_NEXT(a_move_answers_next, start && !busy && move_req, out_valid)
  `PST_ASSERT_NOW(a_refused_move_reads_nothing, out_valid && out_out_of_range, out_read_symbol == '0)
  `PST_ASSERT_NOW(a_second_word_follows_first, state_r == pst_pkg::ST_WR1, $past(state_r) == pst_pkg::ST_RD2)
  `PST_ASSERT_NOW(a_clear_holds_items_off, state_r == pst_pkg::ST_CLEAR, busy && !out_valid)

endmodule
